>>> rtl/hmr_pkg.sv
// Shared types and constants for the histogram match remap block.
`timescale 1ns / 1ps
`default_nettype none

package hmr_pkg;

   // Default table size and count width.
   localparam int NUM_BINS_DEF   = 256;
   localparam int COUNT_BITS_DEF = 24;

   // Fixed widths of the request and response fields.
   localparam int MODE_W      = 2;
   localparam int BIN_INDEX_W = 8;
   localparam int BIN_COUNT_W = 24;
   localparam int PIXEL_W     = 8;
   localparam int REQ_DATA_W  = BIN_INDEX_W + BIN_COUNT_W + PIXEL_W;
   localparam int MAPPED_W    = 8;

   // Request kinds carried in req_tuser.
   typedef enum logic [MODE_W-1:0] {
      MODE_LOAD_SUBJECT = 2'd0,
      MODE_LOAD_TARGET  = 2'd1,
      MODE_BUILD        = 2'd2,
      MODE_PIXEL        = 2'd3
   } mode_type;

   // Controller states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_STORE,
      ST_FINISH
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic accept;       // a request is taken this cycle
      logic scan_rd;      // read the next target bin of the scan
      logic store;        // write the best bin into the remap table
      logic finish_push;  // send the build done response
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic t_last;       // scan is at the last target bin
      logic s_last;       // scan is at the last subject bin
      logic s1_free;      // response stage can take a new entry
   } status_type;

endpackage

`default_nettype wire

>>> rtl/histogram_match_remap.sv
// Top level of the histogram match remap block.
`timescale 1ns / 1ps
`default_nettype none

// Histogram matching by nearest bin count.
// The req_ channel carries one request a transfer: req_tuser selects load subject bin,
// load target bin, build map or remap pixel. Loads write one table bin and give no
// response. A build compares every subject bin with every target bin, one target bin
// a cycle through the target table read port, and answers with rsp_tuser set and
// rsp_tdata zero. A pixel reads the remap table and answers with its mapped value.
// Loads and pixels take one request per cycle while the response stage has room; a pixel
// response passes through the response stage and then the output register. A build
// scans all target bins for each subject bin, with a drain and a store step after each,
// using the single target table port; requests are held off meanwhile, then it responds.
// Responses leave in request order from an output register. When rsp_tready is low,
// one more request is taken into the stage before it, and then req_tready drops.
// Reset clears the controller, the scan counters and the response valid flags; the tables
// hold no reset value, so bins must be loaded before a build and a build run before pixels.

module histogram_match_remap #(
   parameter int NUM_BINS   = hmr_pkg::NUM_BINS_DEF,
   parameter int COUNT_BITS = hmr_pkg::COUNT_BITS_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   // bin_index [7:0], bin_count [31:8], pixel_value [39:32]
   input  wire logic [hmr_pkg::REQ_DATA_W-1:0]    req_tdata,
   // mode [1:0]
   input  wire logic [hmr_pkg::MODE_W-1:0]        req_tuser,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   // mapped_value [7:0]
   output logic [hmr_pkg::MAPPED_W-1:0]           rsp_tdata,
   // build_done [0]
   output logic [0:0]                             rsp_tuser
);

   hmr_pkg::cmd_type    cmd;
   hmr_pkg::status_type status;
   logic                build_done;

   // Request field unpacking.
   logic [hmr_pkg::BIN_INDEX_W-1:0] bin_index;
   logic [hmr_pkg::BIN_COUNT_W-1:0] bin_count;
   logic [hmr_pkg::PIXEL_W-1:0]     pixel_value;

   assign bin_index   = req_tdata[hmr_pkg::BIN_INDEX_W-1:0];
   assign bin_count   = req_tdata[hmr_pkg::BIN_INDEX_W +: hmr_pkg::BIN_COUNT_W];
   assign pixel_value = req_tdata[hmr_pkg::BIN_INDEX_W + hmr_pkg::BIN_COUNT_W +:
                                  hmr_pkg::PIXEL_W];

   hmr_controller u_controller (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_mode   (req_tuser),
      .status     (status),
      .cmd        (cmd)
   );

   hmr_datapath #(
      .NUM_BINS   (NUM_BINS),
      .COUNT_BITS (COUNT_BITS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_mode         (req_tuser),
      .req_bin_index    (bin_index),
      .req_bin_count    (bin_count),
      .req_pixel_value  (pixel_value),
      .rsp_tvalid       (rsp_tvalid),
      .rsp_tready       (rsp_tready),
      .rsp_mapped_value (rsp_tdata),
      .rsp_build_done   (build_done)
   );

   assign rsp_tuser = build_done;

endmodule

`default_nettype wire

>>> rtl/hmr_controller.sv
// Controller state machine for the histogram match remap block.
`timescale 1ns / 1ps
`default_nettype none

module hmr_controller (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_tvalid,
   output logic                                req_tready,
   input  wire logic [hmr_pkg::MODE_W-1:0]     req_mode,
   input  wire hmr_pkg::status_type            status,
   output hmr_pkg::cmd_type                    cmd
);

   hmr_pkg::state_type state_ff;
   hmr_pkg::state_type state_in;
   logic               accept;

   // Requests are taken only while idle and the response stage has room.
   assign req_tready = (state_ff == hmr_pkg::ST_IDLE) && status.s1_free;
   assign accept     = req_tvalid && req_tready;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         hmr_pkg::ST_IDLE: begin
            if (accept && (hmr_pkg::mode_type'(req_mode) == hmr_pkg::MODE_BUILD)) begin
               state_in = hmr_pkg::ST_SCAN;
            end
         end
         hmr_pkg::ST_SCAN: begin
            if (status.t_last) begin
               state_in = hmr_pkg::ST_DRAIN;
            end
         end
         hmr_pkg::ST_DRAIN: begin
            state_in = hmr_pkg::ST_STORE;
         end
         hmr_pkg::ST_STORE: begin
            state_in = status.s_last ? hmr_pkg::ST_FINISH : hmr_pkg::ST_SCAN;
         end
         hmr_pkg::ST_FINISH: begin
            if (status.s1_free) begin
               state_in = hmr_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = hmr_pkg::ST_IDLE;
         end
      endcase
   end

   // Commands to the datapath.
   always_comb begin
      cmd             = '0;
      cmd.accept      = accept;
      case (state_ff)
         hmr_pkg::ST_SCAN: begin
            cmd.scan_rd = 1'b1;
         end
         hmr_pkg::ST_STORE: begin
            cmd.store = 1'b1;
         end
         hmr_pkg::ST_FINISH: begin
            cmd.finish_push = status.s1_free;
         end
         default: begin
            cmd.scan_rd = 1'b0;
         end
      endcase
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= hmr_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

>>> rtl/hmr_datapath.sv
// Datapath of the histogram match remap block: tables, nearest-count scan and response.
`timescale 1ns / 1ps
`default_nettype none

module hmr_datapath #(
   parameter int NUM_BINS   = hmr_pkg::NUM_BINS_DEF,
   parameter int COUNT_BITS = hmr_pkg::COUNT_BITS_DEF
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire hmr_pkg::cmd_type                   cmd,
   output hmr_pkg::status_type                     status,
   input  wire logic [hmr_pkg::MODE_W-1:0]         req_mode,
   input  wire logic [hmr_pkg::BIN_INDEX_W-1:0]    req_bin_index,
   input  wire logic [hmr_pkg::BIN_COUNT_W-1:0]    req_bin_count,
   input  wire logic [hmr_pkg::PIXEL_W-1:0]        req_pixel_value,
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   output logic [hmr_pkg::MAPPED_W-1:0]            rsp_mapped_value,
   output logic                                    rsp_build_done
);

   localparam int IW = $clog2(NUM_BINS);
   localparam int CW = COUNT_BITS;
   localparam logic [IW-1:0] LAST_BIN = IW'(NUM_BINS - 1);

   // Table memories.
   logic [CW-1:0]                  sub_mem [NUM_BINS];
   logic [CW-1:0]                  tgt_mem [NUM_BINS];
   logic [hmr_pkg::MAPPED_W-1:0]   map_mem [NUM_BINS];

   logic [IW-1:0]                  s_cnt_ff, s_cnt_in;
   logic [IW-1:0]                  t_cnt_ff, t_cnt_in;
   logic [CW-1:0]                  sub_q_ff;
   logic [CW-1:0]                  tgt_q_ff;
   logic                           tv_ff;
   logic [IW-1:0]                  tidx_ff;
   logic [CW-1:0]                  best_diff_ff;
   logic [IW-1:0]                  best_bin_ff;
   logic [CW-1:0]                  diff;
   logic                           take_best;

   logic [hmr_pkg::MAPPED_W-1:0]   map_q_ff;
   logic                           s1_vld_ff, s1_vld_in;
   logic                           s1_done_ff;
   logic                           s1_zero_ff;
   logic                           out_vld_ff, out_vld_in;
   logic [hmr_pkg::MAPPED_W-1:0]   out_data_ff;
   logic                           out_done_ff;
   logic                           out_free;
   logic                           s1_load;

   logic [IW-1:0]                  wr_addr;
   logic [IW-1:0]                  pix_addr;
   logic                           bin_in_range;
   logic                           pix_in_range;
   logic                           is_load_sub;
   logic                           is_load_tgt;
   logic                           is_pixel;

   // Request decode.
   assign wr_addr      = IW'(req_bin_index);
   assign pix_addr     = IW'(req_pixel_value);
   assign bin_in_range = 32'(req_bin_index) < NUM_BINS;
   assign pix_in_range = 32'(req_pixel_value) < NUM_BINS;
   assign is_load_sub  = cmd.accept &&
                         (hmr_pkg::mode_type'(req_mode) == hmr_pkg::MODE_LOAD_SUBJECT);
   assign is_load_tgt  = cmd.accept &&
                         (hmr_pkg::mode_type'(req_mode) == hmr_pkg::MODE_LOAD_TARGET);
   assign is_pixel     = cmd.accept &&
                         (hmr_pkg::mode_type'(req_mode) == hmr_pkg::MODE_PIXEL);

   // Subject table: written by loads, read once at the start of each subject scan.
   always_ff @(posedge clock) begin
      if (is_load_sub && bin_in_range) begin
         sub_mem[wr_addr] <= CW'(req_bin_count);
      end
      if (cmd.scan_rd && (t_cnt_ff == '0)) begin
         sub_q_ff <= sub_mem[s_cnt_ff];
      end
   end

   // Target table: written by loads, read one bin a cycle during the scan.
   always_ff @(posedge clock) begin
      if (is_load_tgt && bin_in_range) begin
         tgt_mem[wr_addr] <= CW'(req_bin_count);
      end
      if (cmd.scan_rd) begin
         tgt_q_ff <= tgt_mem[t_cnt_ff];
      end
   end

   // Remap table: written at the end of each subject scan, read by pixels.
   always_ff @(posedge clock) begin
      if (cmd.store) begin
         map_mem[s_cnt_ff] <= hmr_pkg::MAPPED_W'(best_bin_ff);
      end
      if (is_pixel && pix_in_range) begin
         map_q_ff <= map_mem[pix_addr];
      end
   end

   // Scan counters over target bins and subject bins.
   always_comb begin
      t_cnt_in = t_cnt_ff;
      s_cnt_in = s_cnt_ff;
      if (cmd.scan_rd) begin
         t_cnt_in = (t_cnt_ff == LAST_BIN) ? '0 : t_cnt_ff + 1'b1;
      end
      if (cmd.store) begin
         s_cnt_in = (s_cnt_ff == LAST_BIN) ? '0 : s_cnt_ff + 1'b1;
      end
   end

   assign status.t_last = (t_cnt_ff == LAST_BIN);
   assign status.s_last = (s_cnt_ff == LAST_BIN);

   // Nearest count: the first bin seeds the best, later bins win only on a strictly smaller difference.
   assign diff      = (sub_q_ff >= tgt_q_ff) ? (sub_q_ff - tgt_q_ff) : (tgt_q_ff - sub_q_ff);
   assign take_best = tv_ff && ((tidx_ff == '0) || (diff < best_diff_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         s_cnt_ff <= '0;
         t_cnt_ff <= '0;
         tv_ff    <= 1'b0;
      end else begin
         s_cnt_ff <= s_cnt_in;
         t_cnt_ff <= t_cnt_in;
         tv_ff    <= cmd.scan_rd;
      end
   end

   always_ff @(posedge clock) begin
      tidx_ff <= t_cnt_ff;
      if (take_best) begin
         best_diff_ff <= diff;
         best_bin_ff  <= tidx_ff;
      end
   end

   // Response stage and output register.
   assign out_free       = !out_vld_ff || rsp_tready;
   assign status.s1_free = !s1_vld_ff || out_free;
   assign s1_load        = is_pixel || cmd.finish_push;

   always_comb begin
      s1_vld_in = s1_vld_ff;
      if (s1_load) begin
         s1_vld_in = 1'b1;
      end else if (out_free) begin
         s1_vld_in = 1'b0;
      end
      out_vld_in = out_free ? s1_vld_ff : out_vld_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff  <= s1_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_load) begin
         s1_done_ff <= cmd.finish_push;
         s1_zero_ff <= cmd.finish_push || !pix_in_range;
      end
      if (out_free && s1_vld_ff) begin
         out_data_ff <= s1_zero_ff ? '0 : map_q_ff;
         out_done_ff <= s1_done_ff;
      end
   end

   assign rsp_tvalid       = out_vld_ff;
   assign rsp_mapped_value = out_data_ff;
   assign rsp_build_done   = out_done_ff;

endmodule

`default_nettype wire

>>> rtl/hmr_checker.sv
// Port-level checker for the histogram match remap block, with its bind.
`timescale 1ns / 1ps
`default_nettype none

module hmr_checker (
   input wire logic                              clock,
   input wire logic                              reset,
   input wire logic                              req_tvalid,
   input wire logic                              req_tready,
   input wire logic [hmr_pkg::REQ_DATA_W-1:0]    req_tdata,
   input wire logic [hmr_pkg::MODE_W-1:0]        req_tuser,
   input wire logic                              rsp_tvalid,
   input wire logic                              rsp_tready,
   input wire logic [hmr_pkg::MAPPED_W-1:0]      rsp_tdata,
   input wire logic [0:0]                        rsp_tuser
);

   // The cycle after reset shows no response.
   a_reset_quiet: assert property (@(posedge clock) $past(reset) |-> !rsp_tvalid)
      else $error("response valid right after reset");

   // A build done response always carries a zero mapped value.
   a_done_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[0]) |-> (rsp_tdata == '0))
      else $error("build done response with nonzero data");

   // A build request closes the request side on the next cycle.
   a_build_busy: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && (req_tuser == hmr_pkg::MODE_BUILD)) |=> !req_tready)
      else $error("request taken during a build");

   // A stalled response holds its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=>
      (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser)))
      else $error("stalled response changed");

   // A waiting request keeps its payload until it is taken.
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && !req_tready) |=>
      (req_tvalid && $stable(req_tdata) && $stable(req_tuser)))
      else $error("waiting request changed");

endmodule

bind histogram_match_remap hmr_checker u_hmr_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire
